@@ src/tmss_pkg.sv @@
// Shared constants, codes and types for the tile map scroll streamer.
`timescale 1ns / 1ps
`default_nettype none

package tmss_pkg;

  localparam int MaxSideBlocks = 64;
  localparam int SideW         = 7;
  localparam int BlockW        = 12;
  localparam int TopLeftW      = 13;
  localparam int PosW          = 16;
  localparam int ClampW        = 14;
  localparam int ScrollW       = 9;
  localparam int SlotW         = 4;
  localparam int LayerW        = 2;
  localparam int BatchDepth    = 5;
  localparam int CopyDepth     = 4;
  localparam int CountW        = 3;

  localparam int InDataW   = 32;
  localparam int InUserW   = 2;
  localparam int OutDataW  = 40;
  localparam int CfgIndexW = 2;
  localparam int CfgDataW  = 7;

  localparam logic [PosW-1:0] BlockPx = 16'd256;
  localparam logic [7:0]      VMargin = 8'd64;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SCROLL = 2'd1,
    OP_SCREEN = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [CfgIndexW-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_LAYER  = 2'd2;

  localparam logic KIND_COPY   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [BlockW-1:0]    src;
    logic [SlotW-1:0]     slot;
    logic [ScrollW-1:0]   h;
    logic [ScrollW-1:0]   v;
    logic                 last;
  } result_t;

  function automatic logic [SideW-1:0] eff_size(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    if (v == '0) begin
      r = SideW'(1);
    end else if (v > SideW'(MaxSideBlocks)) begin
      r = SideW'(MaxSideBlocks);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ src/tile_map_scroll_streamer_top.sv @@
// Top level of the tile map scroll streamer: input register, map logic and result queue.
`timescale 1ns / 1ps
`default_nettype none

// Streams a background map of 256-pixel blocks through a 2x2 ring of map slots.
// A request enters an input register, is worked combinationally into up to five
// results (block copy commands, then the scroll register values with tlast set)
// and these leave one per cycle while m_tready is high, from a five-entry result
// queue. A load gives five results, a clamped scroll one, three or five, a screen
// scroll one, and operation 3 none. The input register takes a new request
// whenever it is empty or its request moves into the queue, which happens in a
// cycle in which the queue is empty or sends its final result, so the next request
// can wait in the input register while the queue drains; the sustained request
// rate is set by the single result port. A request's first result is offered once
// it is in the queue. Configuration writes are always ready.
module tile_map_scroll_streamer_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // value_x [15:0], value_y [31:16]
  input  wire logic [tmss_pkg::InDataW-1:0]    s_tdata,
  // operation [1:0]
  input  wire logic [tmss_pkg::InUserW-1:0]    s_tuser,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // source_block [11:0], target_slot [15:12], scroll_h [24:16], scroll_v [33:25], zero above
  output logic [tmss_pkg::OutDataW-1:0]        m_tdata,
  // result_kind [0]
  output logic                                 m_tuser,
  output logic                                 m_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tmss_pkg::CfgIndexW-1:0]  cfg_index,
  input  wire logic [tmss_pkg::CfgDataW-1:0]   cfg_data
);
  import tmss_pkg::*;

  logic [SideW-1:0]    map_width;
  logic [SideW-1:0]    map_height;
  logic [LayerW-1:0]   layer;

  logic [PosW-1:0]     world_x;
  logic [PosW-1:0]     world_y;
  logic [PosW-1:0]     screen_pos_x;
  logic [PosW-1:0]     screen_pos_y;
  logic [TopLeftW-1:0] top_left;
  logic                phase_x;
  logic                phase_y;

  logic                in_valid;
  op_t                 in_op;
  logic [PosW-1:0]     in_x;
  logic [PosW-1:0]     in_y;

  result_t             queue [BatchDepth];
  logic [CountW-1:0]   count;

  logic                take;
  logic                advance;

  logic [SideW-1:0]    w;
  logic [SideW-1:0]    h;
  logic [SideW-1:0]    w_m1;
  logic [SideW-1:0]    h_m1;
  logic [ClampW-1:0]   lim_x;
  logic [ClampW-1:0]   lim_y;
  logic signed [PosW:0] lim_x_s;
  logic signed [PosW:0] lim_y_s;
  logic [BlockW-1:0]   w12;
  logic [TopLeftW-1:0] w13;

  // load
  logic                ld_over_x;
  logic                ld_over_y;
  logic                ld_adjust;
  logic [ClampW-1:0]   ld_wx;
  logic [ClampW-1:0]   ld_wy;
  logic [ScrollW-1:0]  ld_sx;
  logic [ScrollW-1:0]  ld_sy;
  logic [TopLeftW-1:0] ld_prod;
  logic [TopLeftW-1:0] ld_tl;

  // clamped scroll
  logic signed [PosW:0] sc_x;
  logic signed [PosW:0] sc_y;
  logic [PosW-1:0]     sc_sx;
  logic [PosW-1:0]     sc_sy;
  logic                sc_over_x;
  logic                sc_over_y;
  logic [PosW-1:0]     cx;
  logic [PosW-1:0]     cy;
  logic [PosW-1:0]     csx;
  logic [PosW-1:0]     csy;
  logic                xplus;
  logic                xminus;
  logic                yplus;
  logic                yminus;
  logic [PosW-1:0]     fsx;
  logic [PosW-1:0]     fsy;
  logic                phase_x1;
  logic                phase_y1;
  logic [TopLeftW-1:0] tl1;
  logic [TopLeftW-1:0] tl2;
  logic [BlockW-1:0]   xsrc0;
  logic [BlockW-1:0]   xsrc1;
  logic [BlockW-1:0]   ysrc0;
  logic [BlockW-1:0]   ysrc1;
  logic                xbit;
  logic                ybit;

  // screen scroll
  logic [PosW-1:0]     ss_x;
  logic [PosW-1:0]     ss_y;

  logic [BlockW-1:0]   cs [BatchDepth];
  logic [SlotW-1:0]    ct [BatchDepth];
  logic [CountW-1:0]   ncopy;
  logic [ScrollW-1:0]  hs;
  logic [ScrollW-1:0]  vs;
  result_t             batch [BatchDepth];
  logic [CountW-1:0]   batch_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= SideW'(1);
      map_height <= SideW'(1);
      layer      <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WIDTH:  map_width  <= cfg_data;
        CFG_HEIGHT: map_height <= cfg_data;
        CFG_LAYER:  layer      <= cfg_data[LayerW-1:0];
        default: ;
      endcase
    end
  end

  assign take     = m_tvalid & m_tready;
  assign advance  = in_valid & ((count == '0) | ((count == CountW'(1)) & take));
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready & s_tvalid) begin
      in_op <= op_t'(s_tuser);
      in_x  <= s_tdata[PosW-1:0];
      in_y  <= s_tdata[2*PosW-1:PosW];
    end
  end

  assign w       = eff_size(map_width);
  assign h       = eff_size(map_height);
  assign w_m1    = w - SideW'(1);
  assign h_m1    = h - SideW'(1);
  assign lim_x   = {w_m1[5:0], 8'd0};
  assign lim_y   = {h_m1[5:0], VMargin};
  assign lim_x_s = $signed({3'b000, lim_x});
  assign lim_y_s = $signed({3'b000, lim_y});
  assign w12     = {5'b00000, w};
  assign w13     = {6'b000000, w};

  // load: clamp the position and locate the top-left block
  assign ld_over_x = $signed({in_x[PosW-1], in_x}) > lim_x_s;
  assign ld_over_y = $signed({in_y[PosW-1], in_y}) > lim_y_s;

  always_comb begin
    ld_adjust = 1'b0;
    if ((w == SideW'(1)) || in_x[PosW-1]) begin
      ld_wx = '0;
      ld_sx = '0;
    end else if (ld_over_x) begin
      ld_wx     = lim_x;
      ld_sx     = BlockPx[ScrollW-1:0];
      ld_adjust = 1'b1;
    end else begin
      ld_wx = in_x[ClampW-1:0];
      ld_sx = {1'b0, in_x[7:0]};
    end
    if (in_y[PosW-1]) begin
      ld_wy = '0;
      ld_sy = '0;
    end else if (ld_over_y) begin
      ld_wy = lim_y;
      ld_sy = {1'b0, VMargin};
    end else begin
      ld_wy = in_y[ClampW-1:0];
      ld_sy = {1'b0, in_y[7:0]};
    end
  end

  assign ld_prod = {7'b0000000, ld_wy[ClampW-1:8]} * w13;
  assign ld_tl   = ld_prod + {7'b0000000, ld_wx[ClampW-1:8]} - {12'd0, ld_adjust};

  // clamped scroll
  assign sc_x  = $signed({world_x[PosW-1], world_x}) + $signed({in_x[PosW-1], in_x});
  assign sc_y  = $signed({world_y[PosW-1], world_y}) + $signed({in_y[PosW-1], in_y});
  assign sc_sx = screen_pos_x + in_x;
  assign sc_sy = screen_pos_y + in_y;
  assign sc_over_x = sc_x > lim_x_s;
  assign sc_over_y = sc_y > lim_y_s;

  always_comb begin
    if (sc_over_x) begin
      cx  = {2'b00, lim_x};
      csx = BlockPx;
    end else if (sc_x[PosW]) begin
      cx  = '0;
      csx = '0;
    end else begin
      cx  = sc_x[PosW-1:0];
      csx = sc_sx;
    end
    if (sc_over_y) begin
      cy  = {2'b00, lim_y};
      csy = {8'd0, VMargin};
    end else if (sc_y[PosW]) begin
      cy  = '0;
      csy = '0;
    end else begin
      cy  = sc_y[PosW-1:0];
      csy = sc_sy;
    end
  end

  assign xplus  = $signed(csx) > $signed(BlockPx);
  assign xminus = csx[PosW-1];
  assign yplus  = $signed(csy) > $signed(BlockPx);
  assign yminus = csy[PosW-1];

  assign fsx = xplus ? (csx - BlockPx) : (xminus ? (csx + BlockPx) : csx);
  assign fsy = yplus ? (csy - BlockPx) : (yminus ? (csy + BlockPx) : csy);

  assign phase_x1 = phase_x ^ (xplus | xminus);
  assign phase_y1 = phase_y ^ (yplus | yminus);

  assign tl1 = xplus ? (top_left + TopLeftW'(1)) :
               (xminus ? (top_left - TopLeftW'(1)) : top_left);
  assign tl2 = yplus ? (tl1 + w13) : (yminus ? (tl1 - w13) : tl1);

  assign xsrc0 = tl1[BlockW-1:0] + (phase_y ? w12 : '0) + {11'd0, xplus};
  assign xsrc1 = tl1[BlockW-1:0] + (phase_y ? '0 : w12) + {11'd0, xplus};
  assign xbit  = xplus ? phase_x : ~phase_x;
  assign ysrc0 = tl2[BlockW-1:0] + (yplus ? w12 : '0) + {11'd0, phase_x1};
  assign ysrc1 = tl2[BlockW-1:0] + (yplus ? w12 : '0) + {11'd0, ~phase_x1};
  assign ybit  = yplus ? phase_y : ~phase_y;

  // screen scroll
  assign ss_x = screen_pos_x + in_x;
  assign ss_y = screen_pos_y + in_y;

  // assemble the results of the held request
  always_comb begin
    for (int i = 0; i < BatchDepth; i++) begin
      cs[i] = '0;
      ct[i] = '0;
    end
    ncopy = '0;
    hs    = '0;
    vs    = '0;
    unique case (in_op)
      OP_LOAD: begin
        cs[0] = ld_tl[BlockW-1:0];
        cs[1] = ld_tl[BlockW-1:0] + BlockW'(1);
        cs[2] = ld_tl[BlockW-1:0] + w12;
        cs[3] = ld_tl[BlockW-1:0] + w12 + BlockW'(1);
        ct[0] = {layer, 2'd0};
        ct[1] = {layer, 2'd1};
        ct[2] = {layer, 2'd2};
        ct[3] = {layer, 2'd3};
        ncopy = CountW'(CopyDepth);
        hs    = ld_sx;
        vs    = ld_sy;
      end
      OP_SCROLL: begin
        if (xplus | xminus) begin
          cs[0] = xsrc0;
          cs[1] = xsrc1;
          ct[0] = {layer, 1'b0, xbit};
          ct[1] = {layer, 1'b1, xbit};
        end
        if (yplus | yminus) begin
          if (xplus | xminus) begin
            cs[2] = ysrc0;
            cs[3] = ysrc1;
            ct[2] = {layer, ybit, 1'b0};
            ct[3] = {layer, ybit, 1'b1};
          end else begin
            cs[0] = ysrc0;
            cs[1] = ysrc1;
            ct[0] = {layer, ybit, 1'b0};
            ct[1] = {layer, ybit, 1'b1};
          end
        end
        ncopy = CountW'(2) * CountW'(xplus | xminus) + CountW'(2) * CountW'(yplus | yminus);
        hs    = {phase_x1 ^ fsx[8], fsx[7:0]};
        vs    = {phase_y1 ^ fsy[8], fsy[7:0]};
      end
      OP_SCREEN: begin
        hs = ss_x[ScrollW-1:0];
        vs = ss_y[ScrollW-1:0];
      end
      OP_NONE: ;
      default: ;
    endcase

    for (int i = 0; i < BatchDepth; i++) begin
      batch[i] = '0;
      if (CountW'(i) < ncopy) begin
        batch[i].kind = KIND_COPY;
        batch[i].src  = cs[i];
        batch[i].slot = ct[i];
      end else if (CountW'(i) == ncopy) begin
        batch[i].kind = KIND_SCROLL;
        batch[i].h    = hs;
        batch[i].v    = vs;
        batch[i].last = 1'b1;
      end
    end
    batch_count = (in_op == OP_NONE) ? '0 : ncopy + CountW'(1);
  end

  // map state
  always_ff @(posedge clk) begin
    if (rst) begin
      world_x      <= '0;
      world_y      <= '0;
      screen_pos_x <= '0;
      screen_pos_y <= '0;
      top_left     <= '0;
      phase_x      <= 1'b0;
      phase_y      <= 1'b0;
    end else if (advance) begin
      unique case (in_op)
        OP_LOAD: begin
          world_x      <= {2'b00, ld_wx};
          world_y      <= {2'b00, ld_wy};
          screen_pos_x <= {7'd0, ld_sx};
          screen_pos_y <= {7'd0, ld_sy};
          top_left     <= ld_tl;
        end
        OP_SCROLL: begin
          world_x      <= cx;
          world_y      <= cy;
          screen_pos_x <= fsx;
          screen_pos_y <= fsy;
          top_left     <= tl2;
          phase_x      <= phase_x1;
          phase_y      <= phase_y1;
        end
        OP_SCREEN: begin
          screen_pos_x <= ss_x;
          screen_pos_y <= ss_y;
        end
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  // result queue: load a whole batch, then shift one result out per result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (advance) begin
      count <= batch_count;
    end else if (take) begin
      count <= count - CountW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < BatchDepth; i++) begin
        queue[i] <= batch[i];
      end
    end else if (take) begin
      for (int i = 0; i < BatchDepth - 1; i++) begin
        queue[i] <= queue[i+1];
      end
    end
  end

  assign m_tvalid = count != '0;
  assign m_tuser  = queue[0].kind;
  assign m_tlast  = queue[0].last;
  assign m_tdata  = {6'd0, queue[0].v, queue[0].h, queue[0].slot, queue[0].src};

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the tile map scroll streamer: predicted copy and scroll requests.
`timescale 1ns / 1ps

module tb;
  import tmss_pkg::*;

  localparam int StallLimit    = 3000;
  localparam int DrainCycles   = 12;
  localparam int HoldOffCycles = 150;
  localparam logic [CfgIndexW-1:0] CfgUnused = 2'd3;

  class map_view_scoreboard;
    logic [SideW-1:0]    width_reg;
    logic [SideW-1:0]    height_reg;
    logic [LayerW-1:0]   layer_reg;
    logic [PosW-1:0]     world_x;
    logic [PosW-1:0]     world_y;
    logic [PosW-1:0]     screen_pos_x;
    logic [PosW-1:0]     screen_pos_y;
    logic [TopLeftW-1:0] top_left;
    bit                  phase_x;
    bit                  phase_y;
    result_t             expected_results[$];
    int                  errors;

    function new();
      width_reg    = 1;
      height_reg   = 1;
      layer_reg    = 0;
      world_x      = 0;
      world_y      = 0;
      screen_pos_x = 0;
      screen_pos_y = 0;
      top_left     = 0;
      phase_x      = 0;
      phase_y      = 0;
      errors       = 0;
    endfunction

    function int side_blocks(logic [SideW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxSideBlocks) return MaxSideBlocks;
      return int'(v);
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void write_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_WIDTH: begin
          width_reg = data;
        end
        CFG_HEIGHT: begin
          height_reg = data;
        end
        CFG_LAYER: begin
          layer_reg = data[LayerW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void push_copy(int offset, int slot_offset);
      result_t r;
      r      = '0;
      r.kind = KIND_COPY;
      r.src  = BlockW'(int'(top_left) + offset);
      r.slot = SlotW'(int'(layer_reg) * 4 + slot_offset);
      expected_results.push_back(r);
    endfunction

    function void predict_request(op_t op, shortint vx, shortint vy);
      int                 w;
      int                 lim_x;
      int                 lim_y;
      int                 x;
      int                 y;
      int                 sx;
      int                 sy;
      bit                 clip_x;
      logic [PosW-1:0]    wrap_x;
      logic [PosW-1:0]    wrap_y;
      logic [ScrollW-1:0] hs;
      logic [ScrollW-1:0] vs;
      result_t            r;
      if (op == OP_NONE) return;
      w     = side_blocks(width_reg);
      lim_x = w * 256 - 256;
      lim_y = side_blocks(height_reg) * 256 - 256 + 64;
      case (op)
        OP_SCREEN: begin
          screen_pos_x = screen_pos_x + PosW'(vx);
          screen_pos_y = screen_pos_y + PosW'(vy);
          hs = screen_pos_x[ScrollW-1:0];
          vs = screen_pos_y[ScrollW-1:0];
        end
        OP_LOAD: begin
          clip_x = 1'b0;
          x  = vx;
          y  = vy;
          sx = (x >= 0) ? x % 256 : 0;
          sy = (y >= 0) ? y % 256 : 0;
          if (w == 1 || x < 0) begin
            x  = 0;
            sx = 0;
          end else if (x > lim_x) begin
            x      = lim_x;
            sx     = 256;
            clip_x = 1'b1;
          end
          if (y < 0) begin
            y  = 0;
            sy = 0;
          end else if (y > lim_y) begin
            y  = lim_y;
            sy = 64;
          end
          world_x      = PosW'(x);
          world_y      = PosW'(y);
          screen_pos_x = PosW'(sx);
          screen_pos_y = PosW'(sy);
          top_left = TopLeftW'((y / 256) * w + x / 256);
          if (clip_x) top_left = top_left - 1'b1;
          push_copy(0, 0);
          push_copy(1, 1);
          push_copy(w, 2);
          push_copy(w + 1, 3);
          hs = screen_pos_x[ScrollW-1:0];
          vs = screen_pos_y[ScrollW-1:0];
        end
        default: begin
          x      = int'(shortint'(world_x)) + vx;
          y      = int'(shortint'(world_y)) + vy;
          wrap_x = screen_pos_x + PosW'(vx);
          wrap_y = screen_pos_y + PosW'(vy);
          sx     = shortint'(wrap_x);
          sy     = shortint'(wrap_y);
          if (x > lim_x) begin
            x  = lim_x;
            sx = 256;
          end else if (x < 0) begin
            x  = 0;
            sx = 0;
          end
          if (y > lim_y) begin
            y  = lim_y;
            sy = 64;
          end else if (y < 0) begin
            y  = 0;
            sy = 0;
          end
          if (sx > 256) begin
            sx       = sx - 256;
            top_left = top_left + 1'b1;
            push_copy(int'(phase_y) * w + 1, int'(phase_x));
            push_copy(int'(phase_y ^ 1'b1) * w + 1, 2 + int'(phase_x));
            phase_x  = ~phase_x;
          end else if (sx < 0) begin
            sx       = sx + 256;
            top_left = top_left - 1'b1;
            phase_x  = ~phase_x;
            push_copy(int'(phase_y) * w, int'(phase_x));
            push_copy(int'(phase_y ^ 1'b1) * w, 2 + int'(phase_x));
          end
          if (sy > 256) begin
            sy       = sy - 256;
            top_left = top_left + TopLeftW'(w);
            push_copy(w + int'(phase_x), 2 * int'(phase_y));
            push_copy(w + int'(phase_x ^ 1'b1), 2 * int'(phase_y) + 1);
            phase_y  = ~phase_y;
          end else if (sy < 0) begin
            sy       = sy + 256;
            top_left = top_left - TopLeftW'(w);
            phase_y  = ~phase_y;
            push_copy(int'(phase_x), 2 * int'(phase_y));
            push_copy(int'(phase_x ^ 1'b1), 2 * int'(phase_y) + 1);
          end
          world_x      = PosW'(x);
          world_y      = PosW'(y);
          screen_pos_x = PosW'(sx);
          screen_pos_y = PosW'(sy);
          hs = ScrollW'(int'(phase_x) * 256 + int'(screen_pos_x));
          vs = ScrollW'(int'(phase_y) * 256 + int'(screen_pos_y));
        end
      endcase
      r      = '0;
      r.kind = KIND_SCROLL;
      r.h    = hs;
      r.v    = vs;
      r.last = 1'b1;
      expected_results.push_back(r);
    endfunction

    function void compare(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_output(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result with nothing pending: kind %0d src %0d slot %0d h %0d v %0d",
               got.kind, got.src, got.slot, got.h, got.v);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare("result_kind", want.kind, got.kind);
      compare("source_block", want.src, got.src);
      compare("target_slot", want.slot, got.slot);
      compare("scroll_h", want.h, got.h);
      compare("scroll_v", want.v, got.v);
      compare("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic [InDataW-1:0]   s_tdata;
  logic [InUserW-1:0]   s_tuser;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [OutDataW-1:0]  m_tdata;
  logic                 m_tuser;
  logic                 m_tlast;
  logic                 m_tvalid;
  logic                 m_tready;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  bit steady;
  bit hold_off_req;
  int map_w;
  int map_h;

  map_view_scoreboard sb = new();

  tile_map_scroll_streamer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_request(input op_t op, input shortint vx, input shortint vy);
    while (!steady && $urandom_range(0, 99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {vy, vx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.predict_request(op, vx, vy);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic program_map(input logic [CfgDataW-1:0] width,
                             input logic [CfgDataW-1:0] height,
                             input logic [CfgDataW-1:0] layer);
    logic [CfgDataW-1:0]  vals [4];
    logic [CfgIndexW-1:0] idx  [4];
    vals = '{width, height, layer, CfgDataW'($urandom)};
    idx  = '{CFG_WIDTH, CFG_HEIGHT, CFG_LAYER, CfgUnused};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_register(idx[i], vals[i]);
    end
    cfg_valid <= 1'b0;
    map_w = sb.side_blocks(width);
    map_h = sb.side_blocks(height);
  endtask

  task automatic random_request(output bit counted);
    int      pick;
    shortint vx;
    shortint vy;
    op_t     op;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      op = OP_LOAD;
      vx = shortint'(int'($urandom_range(0, map_w * 256 + 200)) - 100);
      vy = shortint'(int'($urandom_range(0, map_h * 256 + 264)) - 100);
    end else if (pick < 65) begin
      op = OP_SCROLL;
      vx = shortint'(int'($urandom_range(0, 800)) - 400);
      vy = shortint'(int'($urandom_range(0, 800)) - 400);
    end else if (pick < 75) begin
      op = OP_SCREEN;
      vx = shortint'(int'($urandom_range(0, 600)) - 300);
      vy = shortint'(int'($urandom_range(0, 600)) - 300);
    end else if (pick < 95) begin
      op = op_t'($urandom_range(0, 3));
      vx = shortint'($urandom);
      vy = shortint'($urandom);
    end else begin
      op = OP_NONE;
      vx = shortint'($urandom);
      vy = shortint'($urandom);
    end
    send_request(op, vx, vy);
    counted = (op != OP_NONE);
  endtask

  task automatic run_random(input int quota);
    int done;
    bit counted;
    done = 0;
    while (done < quota) begin
      random_request(counted);
      if (counted) done++;
    end
  endtask

  initial begin : stimulus
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    map_w        = 1;
    map_h        = 1;
    rst          = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    program_map(7'd4, 7'd3, 7'd1);
    send_request(OP_LOAD, 0, 0);
    send_request(OP_LOAD, 32767, 32767);
    send_request(OP_LOAD, -32768, -32768);
    send_request(OP_LOAD, 300, 200);
    send_request(OP_SCROLL, 300, 0);
    send_request(OP_SCROLL, -400, 0);
    send_request(OP_SCROLL, 0, 300);
    send_request(OP_SCROLL, 0, -350);
    send_request(OP_SCROLL, 32767, 32767);
    send_request(OP_SCROLL, -32768, -32768);
    send_request(OP_SCREEN, 32767, 32767);
    send_request(OP_SCREEN, 32767, 32767);
    send_request(OP_SCROLL, 100, -100);
    send_request(OP_SCREEN, -32768, -32768);
    send_request(OP_NONE, -1, -1);
    send_request(OP_LOAD, 500, 400);
    send_request(OP_SCROLL, -1, -1);
    send_request(OP_SCROLL, 257, 257);
    drain();

    // zero width acts as one column, oversize height saturates
    program_map(7'd0, 7'd127, 7'b1111111);
    send_request(OP_LOAD, 1000, 16000);
    send_request(OP_SCROLL, 300, 300);
    send_request(OP_LOAD, -5, 20000);
    send_request(OP_SCROLL, -300, -300);
    drain();

    program_map(7'd64, 7'd64, 7'b1111110);
    run_random(26);
    drain();

    steady = 1'b1;
    program_map(7'd1, 7'd1, 7'd0);
    run_random(26);
    drain();
    steady = 1'b0;

    program_map(7'd2, 7'd2, 7'd1);
    hold_off_req = 1'b1;
    run_random(26);
    drain();

    program_map(CfgDataW'($urandom_range(1, 64)), CfgDataW'($urandom_range(1, 64)),
                CfgDataW'($urandom));
    run_random(26);
    drain();

    program_map(7'd90, 7'd0, 7'd3);
    run_random(26);
    drain();

    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_sink
    int      hold_left;
    bit      hold_done;
    bit      ready_next;
    result_t got;
    hold_left = 0;
    hold_done = 1'b0;
    m_tready  = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.src  = m_tdata[11:0];
        got.slot = m_tdata[15:12];
        got.h    = m_tdata[24:16];
        got.v    = m_tdata[33:25];
        got.last = m_tlast;
        sb.check_output(got);
        sb.compare("tdata padding", '0, m_tdata[OutDataW-1:34]);
      end
      // hold off the output so the block backs up into its input
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = steady || ($urandom_range(0, 99) >= 28);
      end
      m_tready <= ready_next;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
src/tmss_pkg.sv
src/tile_map_scroll_streamer_top.sv
verif/tb.sv
